// ----- hdl/mbba_pkg.sv -----
// ----------------------------------------------------------------------------
// mbba_pkg
// Shared types for the multi-store bitmap block allocator: result codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package mbba_pkg;

   typedef enum logic [1:0] {
      STAT_OK           = 2'd0,
      STAT_FULL         = 2'd1,
      STAT_ALREADY_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SELECT,
      ST_DECIDE,
      ST_SCAN_FIRST,
      ST_SCAN,
      ST_FREE_READ,
      ST_FREE_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       clr_wr;       // write all-ones word, advance clear pointer
      logic       take_req;     // latch request, start store selection
      logic       sel_step;     // compare one store count against the best
      logic       scan_init;    // point the scan at the chosen store
      logic       scan_step;    // read one map word, advance scan pointer
      logic       alloc_commit; // clear lowest free bit, decrement count
      logic       free_read;    // read the map word of the release target
      logic       free_commit;  // set the bit, increment count
      logic       res_set;      // load result staging
      status_type res_code;
      logic       rsp_load;     // move staging into the output register
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sel_last;
      logic best_zero;
      logic word_hit;
      logic free_oob;
      logic bit_free;
      logic rsp_busy;
   } sts_type;

endpackage

// ----- hdl/mbba_datapath.sv -----
// ----------------------------------------------------------------------------
// mbba_datapath
// Free-block bitmap memory, per-store free counts, store selection, word scan
// and the result output register.
// ----------------------------------------------------------------------------
module mbba_datapath
   import mbba_pkg::*;
#(
   parameter int NUM_STORES       = 4,
   parameter int BLOCKS_PER_STORE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_release_store,
   input  logic [9:0]  req_release_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_granted_store,
   output logic [9:0]  rsp_granted_block
);

   localparam int WPS   = (BLOCKS_PER_STORE + 63) / 64;
   localparam int DEPTH = NUM_STORES * WPS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
   localparam int CW    = $clog2(BLOCKS_PER_STORE + 1);
   localparam int OW    = $clog2(WPS + 1);

   logic [63:0]   map_mem [DEPTH];
   logic [63:0]   rdata_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [CW-1:0] count_ff [NUM_STORES];

   logic [1:0]    req_store_ff;
   logic [9:0]    req_block_ff;
   logic [SW-1:0] sel_idx_ff;
   logic [SW-1:0] best_ff;
   logic [CW-1:0] best_cnt_ff;
   logic [AW-1:0] scan_addr_ff;
   logic [OW-1:0] scan_off_ff;
   logic [OW-1:0] hit_off_ff;
   logic [AW-1:0] hit_addr_ff;

   logic [1:0]    res_status_ff;
   logic [1:0]    res_store_ff;
   logic [9:0]    res_block_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [1:0]    rsp_store_ff;
   logic [9:0]    rsp_block_ff;

   logic [AW-1:0] scan_base;
   logic [AW-1:0] free_addr;
   logic [SW-1:0] free_idx;
   logic [SW-1:0] cnt_rd_idx;
   logic [CW-1:0] cnt_rd;
   logic [63:0]   low_bit;
   logic [5:0]    low_pos;
   logic [63:0]   free_mask;
   logic [31:0]   grant_blk;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign scan_base  = AW'(32'(best_ff) * WPS);
   assign free_addr  = AW'(32'(req_store_ff) * WPS + 32'(req_block_ff >> 6));
   assign free_idx   = SW'(req_store_ff);
   assign cnt_rd_idx = cmd.free_commit ? free_idx : sel_idx_ff;
   assign cnt_rd     = count_ff[cnt_rd_idx];
   assign free_mask  = 64'd1 << req_block_ff[5:0];
   assign low_bit    = rdata_ff & (~rdata_ff + 64'd1);
   assign grant_blk  = (32'(hit_off_ff) << 6) | 32'(low_pos);

   // one-hot to binary: each output bit is an OR over its half of the word
   always_comb begin
      low_pos = '0;
      for (int j = 0; j < 6; j++) begin
         for (int i = 0; i < 64; i++) begin
            if (((i >> j) & 1) == 1) begin
               low_pos[j] = low_pos[j] | low_bit[i];
            end
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '1;
      rd_en   = cmd.scan_step | cmd.free_read;
      rd_addr = cmd.free_read ? free_addr : scan_addr_ff;
      if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_commit) begin
         wr_en   = 1'b1;
         wr_addr = hit_addr_ff;
         wr_data = rdata_ff & ~low_bit;
      end else if (cmd.free_commit) begin
         wr_en   = 1'b1;
         wr_addr = free_addr;
         wr_data = rdata_ff | free_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STORES; s++) begin
            count_ff[s] <= CW'(BLOCKS_PER_STORE);
         end
      end else if (cmd.alloc_commit) begin
         count_ff[best_ff] <= best_cnt_ff - CW'(1);
      end else if (cmd.free_commit) begin
         count_ff[free_idx] <= cnt_rd + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_store_ff <= req_release_store;
         req_block_ff <= req_release_block;
         sel_idx_ff   <= '0;
         best_ff      <= '0;
         best_cnt_ff  <= count_ff[0];
      end else if (cmd.sel_step) begin
         if (cnt_rd > best_cnt_ff) begin
            best_ff     <= sel_idx_ff;
            best_cnt_ff <= cnt_rd;
         end
         sel_idx_ff <= sel_idx_ff + SW'(1);
      end
      if (cmd.scan_init) begin
         scan_addr_ff <= scan_base;
         scan_off_ff  <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
         scan_off_ff  <= scan_off_ff + OW'(1);
         hit_addr_ff  <= scan_addr_ff;
         hit_off_ff   <= scan_off_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         if (cmd.alloc_commit) begin
            res_store_ff <= 2'(best_ff);
            res_block_ff <= grant_blk[9:0];
         end else begin
            res_store_ff <= '0;
            res_block_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_store_ff  <= res_store_ff;
         rsp_block_ff  <= res_block_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_store = rsp_store_ff;
   assign rsp_granted_block = rsp_block_ff;

   assign sts.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   assign sts.sel_last  = (sel_idx_ff == SW'(NUM_STORES - 1));
   assign sts.best_zero = (best_cnt_ff == '0);
   assign sts.word_hit  = (rdata_ff != '0);
   assign sts.free_oob  = (32'(req_store_ff) >= NUM_STORES) ||
                          (32'(req_block_ff) >= BLOCKS_PER_STORE);
   assign sts.bit_free  = rdata_ff[req_block_ff[5:0]];
   assign sts.rsp_busy  = rsp_valid_ff & ~rsp_ready;

   // a nonzero count guarantees a hit before the store's words run out
   a_scan_in_store: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_off_ff < OW'(WPS))
      else $error("scan ran past the end of the chosen store");

   a_alloc_has_space: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> best_cnt_ff != '0 && rdata_ff != '0)
      else $error("allocation committed with no free block");

   a_free_bit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.free_commit |-> !sts.bit_free && !sts.free_oob)
      else $error("free committed on a free or out-of-range block");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// ----- hdl/mbba_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbba_ctrl
// Sequencer for the allocator: clearing pass, store selection, map scan,
// free check and result handoff.
// ----------------------------------------------------------------------------
module mbba_ctrl
   import mbba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = req_mode ? ST_FREE_READ : ST_SELECT;
            end
         end
         ST_SELECT: begin
            cmd.sel_step = 1'b1;
            if (sts.sel_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.best_zero) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STAT_FULL;
               state_in     = ST_FINISH;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_FIRST;
            end
         end
         ST_SCAN_FIRST: begin
            cmd.scan_step = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.word_hit) begin
               cmd.alloc_commit = 1'b1;
               cmd.res_set      = 1'b1;
               cmd.res_code     = STAT_OK;
               state_in         = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FREE_READ: begin
            if (sts.free_oob) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STAT_ALREADY_FREE;
               state_in     = ST_FINISH;
            end else begin
               cmd.free_read = 1'b1;
               state_in      = ST_FREE_CHECK;
            end
         end
         ST_FREE_CHECK: begin
            cmd.res_set = 1'b1;
            if (sts.bit_free) begin
               cmd.res_code = STAT_ALREADY_FREE;
            end else begin
               cmd.free_commit = 1'b1;
               cmd.res_code    = STAT_OK;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/multi_store_bitmap_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// multi_store_bitmap_block_allocator_core
// Block allocator over several equal stores with a free bitmap and a free
// count per store; allocates from the emptiest store, lowest block first.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  request | req_valid/req_ready, req_mode,                 | in
//          | req_release_store, req_release_block           |
//  result  | rsp_valid/rsp_ready, rsp_status,               | out
//          | rsp_granted_store, rsp_granted_block           |
//
//  Allocate: a count compare over the stores, then a scan of the chosen
//  store's map, one map word per cycle from a single-port read, then the result.
//  A full allocator answers once the compare is done; a free reads, checks and answers.
//  After reset a clearing pass over all NUM_STORES*ceil(B/64) map words (64 at
//  the defaults) fills the map with ones; no request is taken meanwhile.
//  One request is in flight at a time; a result waiting on rsp_ready
//  holds the next item at its final step.
// ----------------------------------------------------------------------------
module multi_store_bitmap_block_allocator_core
   import mbba_pkg::*;
#(
   parameter int NUM_STORES       = 4,
   parameter int BLOCKS_PER_STORE = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [1:0] req_release_store,
   input  logic [9:0] req_release_block,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_granted_store,
   output logic [9:0] rsp_granted_block
);

   cmd_type cmd;
   sts_type sts;

   mbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbba_datapath #(
      .NUM_STORES       (NUM_STORES),
      .BLOCKS_PER_STORE (BLOCKS_PER_STORE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_release_store (req_release_store),
      .req_release_block (req_release_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_store (rsp_granted_store),
      .rsp_granted_block (rsp_granted_block)
   );

endmodule
